/* rtl/core/wmlqs_pkg.sv */
// Shared types and constants for the weighted multilevel queue scheduler.
`timescale 1ns / 1ps
package wmlqs_pkg;

    localparam int ID_W  = 8;
    localparam int OP_W  = 2;
    localparam int PRI_W = 3;
    localparam int CNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 2'd0,
        OP_PUT_BACK = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_REMOVE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_PUSH,
        ST_SCAN,
        ST_POP,
        ST_GET,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [ID_W-1:0]  proc_id;
        logic [PRI_W-1:0] priority_req;
    } t_in;

    typedef struct packed {
        logic             granted;
        logic [ID_W-1:0]  granted_id;
        logic             overflow;
        logic [CNT_W-1:0] running_count;
    } t_out;

    typedef struct packed {
        logic            wr_en;
        logic [ID_W-1:0] id;
    } t_run_ctl;

endpackage

/* rtl/core/weighted_multilevel_queue_scheduler.sv */
// Top level of the weighted multilevel queue scheduler.
// One item at a time. An add goes through the push state to the result; a
// remove runs a search token that walks the running-list cell chain
// one cell per cycle; a put back then adds a push.
// A dispatch scans the levels one per cycle, then reads the ready-queue
// memory, whose read data is registered.
// A new item is taken once the result is in the output register.
`timescale 1ns / 1ps
module weighted_multilevel_queue_scheduler #(
    parameter int LEVELS      = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  wmlqs_pkg::t_in  i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output wmlqs_pkg::t_out o_out
);

    localparam int LW  = $clog2(LEVELS);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int BW  = $clog2(LEVELS + 1);
    localparam int AW  = $clog2(LEVELS * QUEUE_DEPTH);
    localparam int IDW = wmlqs_pkg::ID_W;
    localparam logic [IDW-1:0] ID_MASK =
        (ID_BITS >= IDW) ? {IDW{1'b1}} : IDW'((1 << ID_BITS) - 1);

    wmlqs_pkg::t_state r_state, n_state;
    wmlqs_pkg::t_op    r_op;
    logic [IDW-1:0]    r_id;
    logic [LW-1:0]     r_idx;
    logic [LW-1:0]     r_last;
    logic              r_has_last;
    logic              r_any_bud;
    logic              r_gnt;
    logic [IDW-1:0]    r_gid;
    logic              r_ovf;
    logic              r_start;
    logic [CW-1:0]     r_size;
    logic [PW-1:0]     r_head [LEVELS];
    logic [CW-1:0]     r_cnt  [LEVELS];
    logic [BW-1:0]     r_bud  [LEVELS];
    logic              r_ov;
    wmlqs_pkg::t_out   r_out;
    logic [IDW-1:0]    r_mem [LEVELS * QUEUE_DEPTH];
    logic [IDW-1:0]    r_rdata;

    logic                accept;
    logic                w_has;
    logic                w_bud;
    logic                w_last_lvl;
    logic                w_full;
    logic [CW:0]         w_sum;
    logic [PW-1:0]       w_pos;
    logic [PW-1:0]       w_head_nx;
    logic [AW-1:0]       w_waddr;
    logic [AW-1:0]       w_raddr;
    logic                w_mwe;
    logic                w_mre;
    logic                w_out_free;
    logic [LW-1:0]       w_lv_sat;
    wmlqs_pkg::t_run_ctl w_ctl;
    logic [QUEUE_DEPTH:0] w_tok;
    logic [QUEUE_DEPTH:0] w_fnd;
    logic [IDW-1:0]      w_ent [QUEUE_DEPTH];

    assign accept     = i_in_valid && o_in_ready;
    assign w_out_free = !r_ov || i_out_ready;
    assign w_has      = r_cnt[r_idx] != '0;
    assign w_bud      = r_bud[r_idx] != '0;
    assign w_last_lvl = r_idx == LW'(LEVELS - 1);
    assign w_full     = r_cnt[r_idx] >= CW'(QUEUE_DEPTH);
    assign w_sum      = (CW+1)'(r_head[r_idx]) + (CW+1)'(r_cnt[r_idx]);
    assign w_pos      = (w_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                        PW'(w_sum - (CW+1)'(QUEUE_DEPTH)) : PW'(w_sum);
    assign w_head_nx  = (r_head[r_idx] == PW'(QUEUE_DEPTH - 1)) ?
                        '0 : r_head[r_idx] + PW'(1);
    assign w_waddr    = AW'(int'(r_idx) * QUEUE_DEPTH + int'(w_pos));
    assign w_raddr    = AW'(int'(r_idx) * QUEUE_DEPTH + int'(r_head[r_idx]));
    assign w_lv_sat   = (32'(i_in.priority_req) >= LEVELS) ?
                        LW'(LEVELS - 1) : LW'(i_in.priority_req);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wmlqs_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (wmlqs_pkg::t_op'(i_in.operation))
                        wmlqs_pkg::OP_ADD:      n_state = wmlqs_pkg::ST_PUSH;
                        wmlqs_pkg::OP_DISPATCH: n_state = wmlqs_pkg::ST_SCAN;
                        default:                n_state = wmlqs_pkg::ST_SWEEP;
                    endcase
                end
            end
            wmlqs_pkg::ST_SWEEP: begin
                if (w_tok[QUEUE_DEPTH]) begin
                    n_state = (r_op == wmlqs_pkg::OP_PUT_BACK) ?
                              wmlqs_pkg::ST_PUSH : wmlqs_pkg::ST_DONE;
                end
            end
            wmlqs_pkg::ST_PUSH: n_state = wmlqs_pkg::ST_DONE;
            wmlqs_pkg::ST_SCAN: begin
                if (w_bud && w_has) begin
                    n_state = wmlqs_pkg::ST_POP;
                end else if (w_last_lvl) begin
                    n_state = (w_has || r_has_last) ?
                              wmlqs_pkg::ST_POP : wmlqs_pkg::ST_DONE;
                end
            end
            wmlqs_pkg::ST_POP: n_state = wmlqs_pkg::ST_GET;
            wmlqs_pkg::ST_GET: n_state = wmlqs_pkg::ST_DONE;
            wmlqs_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = wmlqs_pkg::ST_IDLE;
                end
            end
            default: n_state = wmlqs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = r_state == wmlqs_pkg::ST_IDLE;
        w_mwe        = (r_state == wmlqs_pkg::ST_PUSH) && !w_full;
        w_mre        = r_state == wmlqs_pkg::ST_POP;
        w_ctl.wr_en  = (r_state == wmlqs_pkg::ST_GET) && (r_size < CW'(QUEUE_DEPTH));
        w_ctl.id     = (r_state == wmlqs_pkg::ST_GET) ? r_rdata : r_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wmlqs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mwe) begin
            r_mem[w_waddr] <= r_id;
        end
        if (w_mre) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= '0;
            r_start <= 1'b0;
            r_ov    <= 1'b0;
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l] <= '0;
                r_cnt[l]  <= '0;
                r_bud[l]  <= BW'(LEVELS - l);
            end
        end else begin
            r_start <= accept &&
                       ((i_in.operation == wmlqs_pkg::OP_PUT_BACK) ||
                        (i_in.operation == wmlqs_pkg::OP_REMOVE));
            if ((r_state == wmlqs_pkg::ST_DONE) && w_out_free) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                wmlqs_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_op       <= wmlqs_pkg::t_op'(i_in.operation);
                        r_id       <= i_in.proc_id & ID_MASK;
                        r_idx      <= (i_in.operation == wmlqs_pkg::OP_DISPATCH) ?
                                      '0 : w_lv_sat;
                        r_has_last <= 1'b0;
                        r_any_bud  <= 1'b0;
                        r_gnt      <= 1'b0;
                        r_gid      <= '0;
                        r_ovf      <= 1'b0;
                    end
                end
                wmlqs_pkg::ST_SWEEP: begin
                    if (w_tok[QUEUE_DEPTH] && w_fnd[QUEUE_DEPTH]) begin
                        r_size <= r_size - CW'(1);
                    end
                end
                wmlqs_pkg::ST_PUSH: begin
                    if (w_full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_cnt[r_idx] <= r_cnt[r_idx] + CW'(1);
                    end
                end
                wmlqs_pkg::ST_SCAN: begin
                    if (w_bud && w_has) begin
                        r_bud[r_idx] <= r_bud[r_idx] - BW'(1);
                    end else begin
                        if (w_has) begin
                            r_last     <= r_idx;
                            r_has_last <= 1'b1;
                        end
                        r_any_bud <= r_any_bud || w_bud;
                        if (w_last_lvl) begin
                            if (!(r_any_bud || w_bud)) begin
                                for (int l = 0; l < LEVELS; l++) begin
                                    r_bud[l] <= BW'(LEVELS - l);
                                end
                            end
                            if (!w_has) begin
                                r_idx <= r_last;
                            end
                        end else begin
                            r_idx <= r_idx + LW'(1);
                        end
                    end
                end
                wmlqs_pkg::ST_POP: begin
                    r_head[r_idx] <= w_head_nx;
                    r_cnt[r_idx]  <= r_cnt[r_idx] - CW'(1);
                    r_gnt         <= 1'b1;
                end
                wmlqs_pkg::ST_GET: begin
                    r_gid <= r_rdata;
                    if (w_ctl.wr_en) begin
                        r_size <= r_size + CW'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                wmlqs_pkg::ST_DONE: begin
                    if (w_out_free) begin
                        r_out.granted       <= r_gnt;
                        r_out.granted_id    <= r_gid;
                        r_out.overflow      <= r_ovf;
                        r_out.running_count <= wmlqs_pkg::CNT_W'(r_size);
                    end
                end
                default: ;
            endcase
        end
    end

    assign w_tok[0] = r_start;
    assign w_fnd[0] = 1'b0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        wmlqs_run_cell #(
            .SZW   (CW),
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_size  (r_size),
            .i_tok   (w_tok[g]),
            .i_fnd   (w_fnd[g]),
            .i_right (w_ent[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
            .o_tok   (w_tok[g+1]),
            .o_fnd   (w_fnd[g+1]),
            .o_entry (w_ent[g])
        );
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size <= CW'(QUEUE_DEPTH))
        else $error("running list size past its depth");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok))
        else $error("more than one search token in the cell chain");

    a_idle_no_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (w_tok == '0))
        else $error("item accepted while a search is in flight");

    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.granted) |-> (o_out.granted_id == '0))
        else $error("id shown without a grant");

endmodule

/* rtl/core/wmlqs_run_cell.sv */
// One running-list cell: holds an entry, searches and shifts with a passing token.
`timescale 1ns / 1ps
module wmlqs_run_cell #(
    parameter int SZW   = 5,
    parameter int INDEX = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wmlqs_pkg::t_run_ctl       i_ctl,
    input  logic [SZW-1:0]            i_size,
    input  logic                      i_tok,
    input  logic                      i_fnd,
    input  logic [wmlqs_pkg::ID_W-1:0] i_right,
    output logic                      o_tok,
    output logic                      o_fnd,
    output logic [wmlqs_pkg::ID_W-1:0] o_entry
);

    logic                       r_tok;
    logic                       r_fnd;
    logic [wmlqs_pkg::ID_W-1:0] r_entry;
    logic                       w_in_use;
    logic                       w_fnd;

    assign w_in_use = SZW'(INDEX) < i_size;
    assign w_fnd    = i_fnd || (i_tok && w_in_use && (r_entry == i_ctl.id));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
            r_fnd <= 1'b0;
        end else begin
            r_tok <= i_tok;
            r_fnd <= i_tok && w_fnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok && w_fnd) begin
            r_entry <= i_right;
        end else if (i_ctl.wr_en && (i_size == SZW'(INDEX))) begin
            r_entry <= i_ctl.id;
        end
    end

    assign o_tok   = r_tok;
    assign o_fnd   = r_fnd;
    assign o_entry = r_entry;

endmodule

/* sim/weighted_multilevel_queue_scheduler_tb.sv */
// Self-checking testbench for the weighted multilevel queue scheduler.
`timescale 1ns / 1ps
module weighted_multilevel_queue_scheduler_tb;

    localparam int LEVELS      = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    wmlqs_pkg::t_in  i_in;
    logic            o_out_valid;
    logic            i_out_ready;
    wmlqs_pkg::t_out o_out;

    weighted_multilevel_queue_scheduler #(
        .LEVELS(LEVELS), .QUEUE_DEPTH(QUEUE_DEPTH), .ID_BITS(8)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    logic [7:0]      lvl_ids [LEVELS][$];
    logic [3:0]      budget [LEVELS];
    logic [7:0]      run_list [$];
    wmlqs_pkg::t_out sched_expected [$];
    int              mismatches;
    int              cycles = 0;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              hold_off;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic void refill();
        for (int l = 0; l < LEVELS; l++) budget[l] = 4'(LEVELS - l);
    endfunction

    function automatic logic enqueue_id(int lv, logic [7:0] id);
        if (lvl_ids[lv].size() >= QUEUE_DEPTH) return 1'b1;
        lvl_ids[lv].push_back(id);
        return 1'b0;
    endfunction

    function automatic void unrun(logic [7:0] id);
        foreach (run_list[k]) begin
            if (run_list[k] == id) begin
                run_list.delete(k);
                return;
            end
        end
    endfunction

    function automatic wmlqs_pkg::t_out schedule(wmlqs_pkg::t_in it);
        wmlqs_pkg::t_out r;
        int lv;
        int last;
        int pick;
        bit all_zero;
        r = '0;
        lv = (it.priority_req >= LEVELS) ? LEVELS - 1 : int'(it.priority_req);
        case (wmlqs_pkg::t_op'(it.operation))
            wmlqs_pkg::OP_ADD: r.overflow = enqueue_id(lv, it.proc_id);
            wmlqs_pkg::OP_PUT_BACK: begin
                unrun(it.proc_id);
                r.overflow = enqueue_id(lv, it.proc_id);
            end
            wmlqs_pkg::OP_REMOVE: unrun(it.proc_id);
            default: begin
                last = -1;
                pick = -1;
                all_zero = 1;
                for (int l = 0; l < LEVELS; l++) begin
                    if (lvl_ids[l].size() != 0) last = l;
                    if (budget[l] > 0) begin
                        all_zero = 0;
                        if (lvl_ids[l].size() != 0) begin
                            budget[l]--;
                            pick = l;
                            break;
                        end
                    end
                end
                if (pick < 0) begin
                    if (all_zero) refill();
                    pick = last;
                end
                if (pick >= 0) begin
                    r.granted = 1'b1;
                    r.granted_id = lvl_ids[pick].pop_front();
                    if (run_list.size() < QUEUE_DEPTH) run_list.push_back(r.granted_id);
                    else r.overflow = 1'b1;
                end
            end
        endcase
        r.running_count = 5'(run_list.size());
        return r;
    endfunction

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic send_item(wmlqs_pkg::t_op op, logic [7:0] id, logic [2:0] pri);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= '{operation: op, proc_id: id, priority_req: pri};
        do @(posedge i_clk); while (!o_in_ready);
        sched_expected.push_back(schedule('{operation: op, proc_id: id, priority_req: pri}));
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else if (i_rst_n) begin
            i_out_ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        wmlqs_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (sched_expected.size() == 0) begin
                report("unexpected item", 16'(o_out), 16'h0);
            end else begin
                want = sched_expected.pop_front();
                if (o_out.granted !== want.granted)
                    report("granted", 16'(o_out.granted), 16'(want.granted));
                if (o_out.granted_id !== want.granted_id)
                    report("granted_id", 16'(o_out.granted_id), 16'(want.granted_id));
                if (o_out.overflow !== want.overflow)
                    report("overflow", 16'(o_out.overflow), 16'(want.overflow));
                if (o_out.running_count !== want.running_count)
                    report("running_count", 16'(o_out.running_count),
                        16'(want.running_count));
            end
        end
    end

    task automatic send_random(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99, 0);
            if (r < 35) send_item(wmlqs_pkg::OP_ADD, 8'($urandom), 3'($urandom));
            else if (r < 65) send_item(wmlqs_pkg::OP_DISPATCH, 8'($urandom), 3'($urandom));
            else if (r < 82 && run_list.size() > 0)
                send_item(wmlqs_pkg::OP_PUT_BACK,
                    run_list[$urandom_range(run_list.size() - 1, 0)], 3'($urandom));
            else if (r < 82) send_item(wmlqs_pkg::OP_PUT_BACK, 8'($urandom), 3'($urandom));
            else if (run_list.size() > 0 && r < 95)
                send_item(wmlqs_pkg::OP_REMOVE,
                    run_list[$urandom_range(run_list.size() - 1, 0)], 3'($urandom));
            else send_item(wmlqs_pkg::OP_REMOVE, 8'($urandom), 3'($urandom));
        end
    endtask

    task automatic test_directed();
        send_item(wmlqs_pkg::OP_DISPATCH, 8'h00, 3'd0);
        send_item(wmlqs_pkg::OP_REMOVE, 8'h55, 3'd0);
        send_item(wmlqs_pkg::OP_ADD, 8'hff, 3'd7);
        send_item(wmlqs_pkg::OP_ADD, 8'h00, 3'd0);
        send_item(wmlqs_pkg::OP_ADD, 8'haa, 3'd5);
        send_item(wmlqs_pkg::OP_DISPATCH, 8'hff, 3'd7);
        send_item(wmlqs_pkg::OP_DISPATCH, 8'h00, 3'd0);
        send_item(wmlqs_pkg::OP_PUT_BACK, 8'h00, 3'd3);
        send_item(wmlqs_pkg::OP_PUT_BACK, 8'h77, 3'd1);
        send_item(wmlqs_pkg::OP_DISPATCH, 8'h00, 3'd0);
        send_item(wmlqs_pkg::OP_DISPATCH, 8'h00, 3'd0);
        send_item(wmlqs_pkg::OP_DISPATCH, 8'h00, 3'd0);
        send_item(wmlqs_pkg::OP_REMOVE, 8'hff, 3'd0);
        send_item(wmlqs_pkg::OP_REMOVE, 8'h77, 3'd2);
        send_item(wmlqs_pkg::OP_DISPATCH, 8'h00, 3'd0);
    endtask

    task automatic test_overflow();
        for (int k = 0; k < 18; k++) send_item(wmlqs_pkg::OP_ADD, 8'(k), 3'd2);
        for (int k = 0; k < 20; k++) send_item(wmlqs_pkg::OP_DISPATCH, 8'h0, 3'd0);
        for (int k = 0; k < 6; k++) send_item(wmlqs_pkg::OP_ADD, 8'h11, 3'd4);
        for (int k = 0; k < 3; k++) send_item(wmlqs_pkg::OP_REMOVE, 8'h11, 3'd0);
    endtask

    task automatic test_budget_refill();
        for (int k = 0; k < 40; k++) send_item(wmlqs_pkg::OP_ADD, 8'($urandom), 3'(k % 8));
        for (int k = 0; k < 60; k++) send_item(wmlqs_pkg::OP_DISPATCH, 8'h0, 3'd0);
        for (int k = 0; k < 16; k++) send_item(wmlqs_pkg::OP_REMOVE, 8'($urandom), 3'd0);
        while (run_list.size() > 0) send_item(wmlqs_pkg::OP_REMOVE, run_list[0], 3'd0);
    endtask

    task automatic test_stall();
        hold_off = 300;
        for (int k = 0; k < 12; k++)
            send_item(wmlqs_pkg::OP_ADD, 8'($urandom), 3'($urandom));
    endtask

    initial begin
        mismatches = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b0;
        for (int l = 0; l < LEVELS; l++) lvl_ids[l].delete();
        refill();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_overflow();
        test_budget_refill();
        test_stall();
        send_idle_pct = 22;
        recv_idle_pct = 79;
        send_random(480);
        send_idle_pct = 79;
        recv_idle_pct = 22;
        send_random(480);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(480);
        i_in_valid <= 1'b0;
        while (sched_expected.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && sched_expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

/* sim.f */
rtl/core/wmlqs_pkg.sv
rtl/core/wmlqs_run_cell.sv
rtl/core/weighted_multilevel_queue_scheduler.sv
sim/weighted_multilevel_queue_scheduler_tb.sv
